[hdl/cdf_pkg.sv]
package cdf_pkg;

  // Reset value of the similarity threshold: 0.6 in signed Q1.15
  localparam logic signed [15:0] THRESH_RESET = 16'sd19661;

  // Commands carried with each element
  localparam logic CMD_PRELOAD = 1'b0;
  localparam logic CMD_CHECK   = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] element_value;
    logic               last_element;
  } in_t;

  typedef struct packed {
    logic       is_duplicate;
    logic       was_stored;
    logic       store_full;
    logic [7:0] entry_index;
    logic [8:0] entry_count;
  } out_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DOT,
    B_CMP,
    B_MUL,
    B_NEXT,
    B_STORE,
    B_COPY,
    B_DONE
  } back_state_t;

endpackage

[hdl/cdf_queue.sv]
module cdf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rp_r];

  // Store pushed descriptors
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wp_r] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) begin
        wp_r <= ~wp_r;
      end
      if (pop && not_empty) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && not_empty};
    end
  end

endmodule

[hdl/cdf_front.sv]
module cdf_front #(
  parameter int L    = 128,
  parameter int PCW  = 8,
  parameter int DOTW = 39
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cdf_pkg::in_t          in_data,
  output logic                  job_push,
  output logic                  job_cmd,
  output logic [DOTW-1:0]       job_n1,
  output logic [PCW-1:0]        job_len,
  input  logic                  job_full,
  input  logic                  buf_release,
  input  logic [$clog2(L)-1:0]  rd_addr,
  output logic signed [15:0]    rd_data
);

  localparam int LW = $clog2(L);

  logic signed [15:0] buf_mem [L];
  logic [PCW-1:0]     pos_r;
  logic [DOTW-1:0]    n1_r;
  logic               busy_r;
  logic               accept;
  logic               room;
  logic signed [31:0] sq;
  logic [DOTW-1:0]    n1_nxt;
  logic [PCW-1:0]     pos_nxt;

  assign in_ready = !busy_r && !job_full;
  assign accept   = in_valid && in_ready;
  assign room     = (pos_r < PCW'(L));
  assign sq       = in_data.element_value * in_data.element_value;
  assign n1_nxt   = room ? n1_r + DOTW'($unsigned(sq)) : n1_r;
  assign pos_nxt  = room ? pos_r + 1'b1 : pos_r;

  assign job_push = accept && in_data.last_element;
  assign job_cmd  = in_data.cmd;
  assign job_n1   = n1_nxt;
  assign job_len  = pos_nxt;

  // Write incoming elements, drop those beyond the vector length
  always_ff @(posedge clk) begin
    if (accept && room) begin
      buf_mem[pos_r[LW-1:0]] <= in_data.element_value;
    end
  end

  // Registered read port for the back end
  always_ff @(posedge clk) begin
    rd_data <= buf_mem[rd_addr];
  end

  // Track position, running norm and buffer ownership
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      n1_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      if (buf_release) begin
        busy_r <= 1'b0;
      end
      if (accept) begin
        if (in_data.last_element) begin
          pos_r  <= '0;
          n1_r   <= '0;
          busy_r <= 1'b1;
        end else begin
          pos_r <= pos_nxt;
          n1_r  <= n1_nxt;
        end
      end
    end
  end

endmodule

[hdl/cdf_back.sv]
module cdf_back #(
  parameter int L    = 128,
  parameter int ME   = 256,
  parameter int PCW  = 8,
  parameter int DOTW = 39
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic signed [15:0]    thr,
  input  logic                  job_valid,
  input  logic                  job_cmd,
  input  logic [DOTW-1:0]       job_n1,
  input  logic [PCW-1:0]        job_len,
  output logic                  job_pop,
  output logic                  buf_release,
  output logic [$clog2(L)-1:0]  rd_addr,
  input  logic signed [15:0]    rd_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cdf_pkg::out_t         out_data
);

  localparam int LW    = $clog2(L);
  localparam int EW    = (ME > 1) ? $clog2(ME) : 1;
  localparam int CW    = $clog2(ME + 1);
  localparam int SAW   = (ME * L > 1) ? $clog2(ME * L) : 1;
  localparam int MAGW  = DOTW + 15;
  localparam int PRODW = 2 * DOTW + 30;

  cdf_pkg::back_state_t state_r, state_nxt;

  logic signed [15:0] vmem [ME * L];
  logic [DOTW-1:0]    nmem [ME];

  logic               cmd_r;
  logic [DOTW-1:0]    n1_r;
  logic [PCW-1:0]     len_r;
  logic [CW-1:0]      ent_r;
  logic [CW-1:0]      cnt_r;
  logic [SAW:0]       base_r;
  logic [SAW:0]       store_base_r;
  logic [PCW-1:0]     iss_r;
  logic [PCW-1:0]     widx_r;
  logic               rv_r;
  logic               rmask_r;
  logic               pv_r;
  logic signed [31:0] prod_r;
  logic signed [DOTW-1:0] dot_r;
  logic signed [15:0] vrd_r;
  logic [DOTW-1:0]    nrd_r;
  logic [31:0]        tsq_r;
  logic [PRODW-1:0]   mc_r;
  logic [MAGW-1:0]    mr_r;
  logic [PRODW-1:0]   acc_r;
  logic [PRODW-1:0]   a_r;
  logic [1:0]         mstep_r;
  logic               res_dup_r;
  logic               res_stored_r;
  logic               res_full_r;
  logic [CW-1:0]      res_idx_r;
  logic               out_valid_r;
  cdf_pkg::out_t      out_r;

  logic               issuing;
  logic               done_fire;
  logic signed [15:0] elem;
  logic [SAW:0]       vaddr;
  logic [SAW:0]       waddr;
  logic [15:0]        tmag;
  logic [DOTW-1:0]    absdot;
  logic [MAGW-1:0]    lmag;
  logic               tneg;
  logic               tzero;
  logic               cmp_quick;
  logic               cmp_match;
  logic               mul_match;
  logic [CW+8:0]      idx_ext;
  logic [CW+8:0]      cnt_ext;

  // Decode threshold sign and dot magnitude
  always_comb begin
    tneg   = thr[15];
    tzero  = (thr == 16'sd0);
    tmag   = tneg ? (~thr + 16'd1) : thr;
    absdot = dot_r[DOTW-1] ? $unsigned(-dot_r) : $unsigned(dot_r);
    lmag   = {absdot, 15'd0};
  end

  // Decide the similarity test where signs settle it
  always_comb begin
    cmp_quick = 1'b1;
    cmp_match = 1'b0;
    if (n1_r == '0 || nrd_r == '0) begin
      cmp_match = tneg;
    end else if (tneg && !dot_r[DOTW-1]) begin
      cmp_match = 1'b1;
    end else if (tzero) begin
      cmp_match = (dot_r > 0);
    end else if (!tneg && (dot_r <= 0)) begin
      cmp_match = 1'b0;
    end else begin
      cmp_quick = 1'b0;
    end
    mul_match = tneg ? (a_r < acc_r) : (a_r > acc_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cdf_pkg::B_IDLE: begin
        if (job_valid) begin
          state_nxt = (job_cmd == cdf_pkg::CMD_CHECK && cnt_r != '0) ?
                      cdf_pkg::B_DOT : cdf_pkg::B_STORE;
        end
      end
      cdf_pkg::B_DOT: begin
        if (iss_r == PCW'(L) && !rv_r && !pv_r) begin
          state_nxt = cdf_pkg::B_CMP;
        end
      end
      cdf_pkg::B_CMP: begin
        if (!cmp_quick) begin
          state_nxt = cdf_pkg::B_MUL;
        end else begin
          state_nxt = cmp_match ? cdf_pkg::B_DONE : cdf_pkg::B_NEXT;
        end
      end
      cdf_pkg::B_MUL: begin
        if (mr_r == '0 && mstep_r == 2'd2) begin
          state_nxt = mul_match ? cdf_pkg::B_DONE : cdf_pkg::B_NEXT;
        end
      end
      cdf_pkg::B_NEXT: begin
        state_nxt = (ent_r + 1'b1 == cnt_r) ? cdf_pkg::B_STORE : cdf_pkg::B_DOT;
      end
      cdf_pkg::B_STORE: begin
        state_nxt = (cnt_r < CW'(ME)) ? cdf_pkg::B_COPY : cdf_pkg::B_DONE;
      end
      cdf_pkg::B_COPY: begin
        if (iss_r == PCW'(L) && !rv_r) begin
          state_nxt = cdf_pkg::B_DONE;
        end
      end
      cdf_pkg::B_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = cdf_pkg::B_IDLE;
        end
      end
      default: state_nxt = cdf_pkg::B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    job_pop     = (state_r == cdf_pkg::B_IDLE) && job_valid;
    done_fire   = (state_r == cdf_pkg::B_DONE) && (!out_valid_r || out_ready);
    buf_release = done_fire;
    issuing     = (state_r == cdf_pkg::B_DOT || state_r == cdf_pkg::B_COPY) &&
                  (iss_r < PCW'(L));
    rd_addr     = iss_r[LW-1:0];
    vaddr       = base_r + (SAW + 1)'(iss_r);
    waddr       = store_base_r + (SAW + 1)'(widx_r);
    elem        = rmask_r ? rd_data : 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdf_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Vector store: read during dot products, write during copy
  always_ff @(posedge clk) begin
    vrd_r <= vmem[vaddr[SAW-1:0]];
    if (rv_r && state_r == cdf_pkg::B_COPY) begin
      vmem[waddr[SAW-1:0]] <= elem;
    end
  end

  // Norm store: read the current entry, write on store
  always_ff @(posedge clk) begin
    nrd_r <= nmem[ent_r[EW-1:0]];
    if (state_r == cdf_pkg::B_STORE && cnt_r < CW'(ME)) begin
      nmem[cnt_r[EW-1:0]] <= n1_r;
    end
  end

  // Square the threshold magnitude
  always_ff @(posedge clk) begin
    tsq_r <= tmag * tmag;
  end

  // Datapath: element pipeline, serial multiplier, result bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      store_base_r <= '0;
      rv_r         <= 1'b0;
      pv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rv_r    <= issuing;
      rmask_r <= (iss_r < len_r);
      widx_r  <= iss_r;
      pv_r    <= rv_r && (state_r == cdf_pkg::B_DOT);
      prod_r  <= elem * vrd_r;
      if (issuing) begin
        iss_r <= iss_r + 1'b1;
      end

      unique case (state_r)
        cdf_pkg::B_IDLE: begin
          if (job_valid) begin
            cmd_r        <= job_cmd;
            n1_r         <= job_n1;
            len_r        <= job_len;
            ent_r        <= '0;
            base_r       <= '0;
            iss_r        <= '0;
            dot_r        <= '0;
            res_dup_r    <= 1'b0;
            res_stored_r <= 1'b0;
            res_full_r   <= 1'b0;
            res_idx_r    <= '0;
          end
        end
        cdf_pkg::B_DOT: begin
          if (pv_r) begin
            dot_r <= dot_r + DOTW'(prod_r);
          end
        end
        cdf_pkg::B_CMP: begin
          mc_r    <= PRODW'(lmag);
          mr_r    <= lmag;
          acc_r   <= '0;
          mstep_r <= 2'd0;
          if (cmp_quick && cmp_match) begin
            res_dup_r <= 1'b1;
            res_idx_r <= ent_r;
          end
        end
        cdf_pkg::B_MUL: begin
          if (mr_r != '0) begin
            if (mr_r[0]) begin
              acc_r <= acc_r + mc_r;
            end
            mc_r <= mc_r << 1;
            mr_r <= mr_r >> 1;
          end else begin
            case (mstep_r)
              2'd0: begin
                a_r     <= acc_r;
                mc_r    <= PRODW'(tsq_r);
                mr_r    <= MAGW'(n1_r);
                acc_r   <= '0;
                mstep_r <= 2'd1;
              end
              2'd1: begin
                mc_r    <= acc_r;
                mr_r    <= MAGW'(nrd_r);
                acc_r   <= '0;
                mstep_r <= 2'd2;
              end
              default: begin
                if (mul_match) begin
                  res_dup_r <= 1'b1;
                  res_idx_r <= ent_r;
                end
              end
            endcase
          end
        end
        cdf_pkg::B_NEXT: begin
          ent_r  <= ent_r + 1'b1;
          base_r <= base_r + (SAW + 1)'(L);
          iss_r  <= '0;
          dot_r  <= '0;
        end
        cdf_pkg::B_STORE: begin
          iss_r <= '0;
          if (cnt_r >= CW'(ME)) begin
            res_full_r <= 1'b1;
          end
        end
        cdf_pkg::B_COPY: begin
          if (iss_r == PCW'(L) && !rv_r) begin
            res_stored_r <= 1'b1;
            res_idx_r    <= cnt_r;
            cnt_r        <= cnt_r + 1'b1;
            store_base_r <= store_base_r + (SAW + 1)'(L);
          end
        end
        default: begin
        end
      endcase

      // Hold the result until taken, load the next one behind it
      out_valid_r <= done_fire || (out_valid_r && !out_ready);
      if (done_fire) begin
        out_r.is_duplicate <= res_dup_r;
        out_r.was_stored   <= res_stored_r;
        out_r.store_full   <= res_full_r;
        out_r.entry_index  <= idx_ext[7:0];
        out_r.entry_count  <= cnt_ext[8:0];
      end
    end
  end

  assign idx_ext   = {9'd0, res_idx_r};
  assign cnt_ext   = {9'd0, cnt_r};
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ME))
    else $error("stored count beyond capacity");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |-> $onehot({res_dup_r, res_stored_r, res_full_r}))
    else $error("result must carry exactly one outcome");

  a_copy_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cdf_pkg::B_COPY |-> cnt_r < CW'(ME))
    else $error("copy started into a full store");

  a_dot_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cdf_pkg::B_DOT |-> ent_r < cnt_r)
    else $error("compare against an unwritten entry");

  a_dup_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire && res_dup_r |-> cmd_r == cdf_pkg::CMD_CHECK)
    else $error("duplicate reported for a preload");

endmodule

[hdl/cosine_duplicate_embedding_filter.sv]
// Elements are taken one per cycle while in_ready is high; the next vector waits until this
// result is registered. A preload, or a check against an empty store, goes to the store
// state and copies the vector if there is room. A check walks the stored entries: one
// 16x16 multiplier forms each dot product; a bit-serial one settles what the signs do not.
// Reset (synchronous, active low) empties the store at once and sets the threshold
// to 19661; the vector stores need no clearing pass.
module cosine_duplicate_embedding_filter #(
  parameter int VECTOR_LENGTH = 128,
  parameter int MAX_ENTRIES   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdf_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cdf_pkg::out_t      out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_data
);

  localparam int LW   = $clog2(VECTOR_LENGTH);
  localparam int PCW  = $clog2(VECTOR_LENGTH + 1);
  localparam int DOTW = 32 + $clog2(VECTOR_LENGTH);
  localparam int JW   = 1 + DOTW + PCW;

  logic signed [15:0] thr_r;
  logic               f_push;
  logic               f_cmd;
  logic [DOTW-1:0]    f_n1;
  logic [PCW-1:0]     f_len;
  logic               q_full;
  logic               q_valid;
  logic [JW-1:0]      q_data;
  logic               b_pop;
  logic               b_release;
  logic [LW-1:0]      b_rd_addr;
  logic signed [15:0] f_rd_data;

  // Threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= cdf_pkg::THRESH_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  cdf_front #(
    .L    (VECTOR_LENGTH),
    .PCW  (PCW),
    .DOTW (DOTW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .job_push    (f_push),
    .job_cmd     (f_cmd),
    .job_n1      (f_n1),
    .job_len     (f_len),
    .job_full    (q_full),
    .buf_release (b_release),
    .rd_addr     (b_rd_addr),
    .rd_data     (f_rd_data)
  );

  cdf_queue #(
    .W (JW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_cmd, f_n1, f_len}),
    .full      (q_full),
    .pop       (b_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  cdf_back #(
    .L    (VECTOR_LENGTH),
    .ME   (MAX_ENTRIES),
    .PCW  (PCW),
    .DOTW (DOTW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .thr         (thr_r),
    .job_valid   (q_valid),
    .job_cmd     (q_data[JW-1]),
    .job_n1      (q_data[JW-2:PCW]),
    .job_len     (q_data[PCW-1:0]),
    .job_pop     (b_pop),
    .buf_release (b_release),
    .rd_addr     (b_rd_addr),
    .rd_data     (f_rd_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
